FILE: design/assert_macros.svh
// Assertion helpers included by the sampler design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge of clk, off while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same check, with no reset gating.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/cgss_pkg.sv
// ----------------------------------------------------------------------------
// cgss_pkg
// Types, codes and constants of the chunk grid stride sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package cgss_pkg;

  // Status codes of a result transaction.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_SHAPE = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_EXHAUSTED = 2'd3;

  // Request kinds.
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_NEXT  = 1'b1;

  // Register indexes.
  localparam logic [2:0] REG_SHAPE_Z = 3'd0;
  localparam logic [2:0] REG_SHAPE_Y = 3'd1;
  localparam logic [2:0] REG_SHAPE_X = 3'd2;
  localparam logic [2:0] REG_CHUNK_Z = 3'd3;
  localparam logic [2:0] REG_CHUNK_Y = 3'd4;
  localparam logic [2:0] REG_CHUNK_X = 3'd5;
  localparam logic [2:0] REG_LEVEL   = 3'd6;
  localparam logic [2:0] REG_SEED    = 3'd7;

  // Mixer constants.
  localparam logic [63:0] MIX_ADD = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_M1  = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_M2  = 64'h94d049bb133111eb;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned CNT_W  = 7;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic          go;
    alu_op_t       op;
    logic [63:0]   a;
    logic [63:0]   b;
  } alu_req_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic [63:0]   quo;
    logic [63:0]   rem;
  } alu_rsp_t;

  // First mixer round: offset, then xor with the value shifted right by 30.
  function automatic logic [63:0] mix_pre(input logic [63:0] v);
    logic [63:0] t;
    t = v + MIX_ADD;
    return t ^ (t >> 30);
  endfunction

endpackage

`default_nettype wire

FILE: design/chunk_grid_stride_sampler.sv
// A request is served by a sequence of operations on the shared unit, one at a time.
// Next request: two divides; start: grid divides and products, then the mixer and the
// coprime search, cut short on grid overflow, an empty selection or a one-chunk grid.
// Invalid shape and exhausted answer without the shared unit; the next request is taken
// in the same cycle as the result turns valid, while at most one earlier result still waits.
// Reset (rst, synchronous) restores control, walk and configuration registers to defaults; next reports exhausted.
// ----------------------------------------------------------------------------
// chunk_grid_stride_sampler
// Sequencer that builds the chunk grid, seeds a coprime stride walk and
// emits chunk keys one request at a time over a shared arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module chunk_grid_stride_sampler (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [31:0]  s_tdata,   // wanted_count[31:0]
  input  wire  [0:0]   s_tuser,   // req_type[0]
  output logic         m_tvalid,
  input  wire          m_tready,
  output logic [143:0] m_tdata,   // selected_count[31:0], key_level[47:32],
                                  // key_z[78:48], key_y[109:79], key_x[140:110], zero
  output logic [1:0]   m_tuser,   // status[1:0]
  output logic         m_tlast,   // is_last
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire  [2:0]   cfg_index,
  input  wire  [63:0]  cfg_data
);
  import cgss_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_GZ   = 14'b00000000000010,
    S_GY   = 14'b00000000000100,
    S_GX   = 14'b00000000001000,
    S_T1   = 14'b00000000010000,
    S_LIM  = 14'b00000000100000,
    S_T2   = 14'b00000001000000,
    S_M1   = 14'b00000010000000,
    S_M2   = 14'b00000100000000,
    S_MOD  = 14'b00001000000000,
    S_GCD  = 14'b00010000000000,
    S_K1   = 14'b00100000000000,
    S_K2   = 14'b01000000000000,
    S_DONE = 14'b10000000000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [30:0] shape_z, shape_y, shape_x;
  logic [30:0] chunk_z, chunk_y, chunk_x;
  logic [15:0] pyramid_level;
  logic [63:0] seed_value;

  // Walk state.
  logic [30:0] grid_z, grid_y, grid_x;
  logic [63:0] total_chunks;
  logic [63:0] stride;
  logic [63:0] position;
  logic [31:0] remaining;

  // Working registers.
  logic [31:0] wanted;
  logic [63:0] tmp;
  logic        mix_second;
  logic [63:0] cand;
  logic [63:0] gb;

  // Result registers.
  logic [1:0]  res_status;
  logic [31:0] res_sel;
  logic [15:0] res_level;
  logic [30:0] res_z, res_y, res_x;
  logic        res_last;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic        any_zero;
  logic [63:0] sel_w;
  logic [63:0] prod_mix;
  logic [63:0] hash;
  logic [63:0] cand_inc;
  logic [63:0] gap;
  logic [31:0] remaining_dec;

  cgss_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // Helper values for the sequencer.
  always_comb begin
    any_zero = (shape_z == '0) || (shape_y == '0) || (shape_x == '0) ||
               (chunk_z == '0) || (chunk_y == '0) || (chunk_x == '0);
    sel_w    = ({32'd0, wanted} < alu_rsp.rem) ? {32'd0, wanted} : alu_rsp.rem;
    prod_mix = alu_rsp.rem ^ (alu_rsp.rem >> 27);
    hash     = alu_rsp.rem ^ (alu_rsp.rem >> 31);
    cand_inc = ((cand + 64'd1) == total_chunks) ? 64'd1 : (cand + 64'd1);
    gap      = total_chunks - position;
    remaining_dec = remaining - 32'd1;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      shape_z <= 31'd1; shape_y <= 31'd1; shape_x <= 31'd1;
      chunk_z <= 31'd1; chunk_y <= 31'd1; chunk_x <= 31'd1;
      pyramid_level <= '0;
      seed_value    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SHAPE_Z: shape_z <= cfg_data[30:0];
        REG_SHAPE_Y: shape_y <= cfg_data[30:0];
        REG_SHAPE_X: shape_x <= cfg_data[30:0];
        REG_CHUNK_Z: chunk_z <= cfg_data[30:0];
        REG_CHUNK_Y: chunk_y <= cfg_data[30:0];
        REG_CHUNK_X: chunk_x <= cfg_data[30:0];
        REG_LEVEL:   pyramid_level <= cfg_data[15:0];
        REG_SEED:    seed_value <= cfg_data;
        default: ;
      endcase
    end
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      alu_req.go   <= 1'b0;
      m_tvalid     <= 1'b0;
      grid_z       <= 31'd1;
      grid_y       <= 31'd1;
      grid_x       <= 31'd1;
      total_chunks <= 64'd1;
      stride       <= 64'd1;
      position     <= '0;
      remaining    <= '0;
      mix_second   <= 1'b0;
    end else begin
      alu_req.go <= 1'b0;
      // The result register is refilled in S_DONE, so it is only cleared elsewhere.
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            wanted     <= s_tdata;
            res_status <= ST_OK;
            res_sel    <= '0;
            res_level  <= '0;
            res_z      <= '0;
            res_y      <= '0;
            res_x      <= '0;
            res_last   <= 1'b0;
            mix_second <= 1'b0;
            if (s_tuser[0] == REQ_START) begin
              if (any_zero) begin
                remaining  <= '0;
                res_status <= ST_BAD_SHAPE;
                state      <= S_DONE;
              end else begin
                alu_req <= '{go: 1'b1, op: OP_DIV,
                             a: {32'd0, ({1'b0, shape_z} + {1'b0, chunk_z} - 32'd1)},
                             b: {33'd0, chunk_z}};
                state <= S_GZ;
              end
            end else if (remaining == '0 || total_chunks == '0 ||
                         grid_x == '0 || grid_y == '0) begin
              res_status <= ST_EXHAUSTED;
              state      <= S_DONE;
            end else begin
              alu_req <= '{go: 1'b1, op: OP_DIV, a: position, b: {33'd0, grid_x}};
              state   <= S_K1;
            end
          end
        end
        S_GZ: begin
          if (alu_rsp.done) begin
            grid_z  <= alu_rsp.quo[30:0];
            alu_req <= '{go: 1'b1, op: OP_DIV,
                         a: {32'd0, ({1'b0, shape_y} + {1'b0, chunk_y} - 32'd1)},
                         b: {33'd0, chunk_y}};
            state <= S_GY;
          end
        end
        S_GY: begin
          if (alu_rsp.done) begin
            grid_y  <= alu_rsp.quo[30:0];
            alu_req <= '{go: 1'b1, op: OP_DIV,
                         a: {32'd0, ({1'b0, shape_x} + {1'b0, chunk_x} - 32'd1)},
                         b: {33'd0, chunk_x}};
            state <= S_GX;
          end
        end
        S_GX: begin
          if (alu_rsp.done) begin
            grid_x  <= alu_rsp.quo[30:0];
            alu_req <= '{go: 1'b1, op: OP_MUL, a: {33'd0, grid_z}, b: {33'd0, grid_y}};
            state   <= S_T1;
          end
        end
        // The limit for the second product is the all-ones word over grid_x.
        S_T1: begin
          if (alu_rsp.done) begin
            tmp     <= alu_rsp.rem;
            alu_req <= '{go: 1'b1, op: OP_DIV, a: '1, b: {33'd0, grid_x}};
            state   <= S_LIM;
          end
        end
        S_LIM: begin
          if (alu_rsp.done) begin
            if (tmp > alu_rsp.quo) begin
              remaining  <= '0;
              res_status <= ST_OVERFLOW;
              state      <= S_DONE;
            end else begin
              alu_req <= '{go: 1'b1, op: OP_MUL, a: tmp, b: {33'd0, grid_x}};
              state   <= S_T2;
            end
          end
        end
        S_T2: begin
          if (alu_rsp.done) begin
            total_chunks <= alu_rsp.rem;
            remaining    <= sel_w[31:0];
            res_sel      <= sel_w[31:0];
            if (sel_w == '0) begin
              state <= S_DONE;
            end else begin
              alu_req <= '{go: 1'b1, op: OP_MUL, a: mix_pre(seed_value), b: MIX_M1};
              state   <= S_M1;
            end
          end
        end
        S_M1: begin
          if (alu_rsp.done) begin
            alu_req <= '{go: 1'b1, op: OP_MUL, a: prod_mix, b: MIX_M2};
            state   <= S_M2;
          end
        end
        S_M2: begin
          if (alu_rsp.done) begin
            alu_req <= '{go: 1'b1, op: OP_DIV, a: hash, b: total_chunks};
            state   <= S_MOD;
          end
        end
        // First pass gives the position, second (skipped for a one-chunk grid) the stride candidate.
        S_MOD: begin
          if (alu_rsp.done) begin
            if (!mix_second) begin
              position <= alu_rsp.rem;
              if (total_chunks == 64'd1) begin
                cand    <= 64'd1;
                gb      <= total_chunks;
                alu_req <= '{go: 1'b1, op: OP_DIV, a: 64'd1, b: total_chunks};
                state   <= S_GCD;
              end else begin
                mix_second <= 1'b1;
                alu_req <= '{go: 1'b1, op: OP_MUL, a: mix_pre(seed_value + 64'd1),
                             b: MIX_M1};
                state   <= S_M1;
              end
            end else begin
              cand    <= (alu_rsp.rem == '0) ? 64'd1 : alu_rsp.rem;
              gb      <= total_chunks;
              alu_req <= '{go: 1'b1, op: OP_DIV,
                           a: (alu_rsp.rem == '0) ? 64'd1 : alu_rsp.rem,
                           b: total_chunks};
              state   <= S_GCD;
            end
          end
        end
        // Euclid over the shared divider; a non-coprime candidate is raised.
        S_GCD: begin
          if (alu_rsp.done) begin
            if (alu_rsp.rem != '0) begin
              gb      <= alu_rsp.rem;
              alu_req <= '{go: 1'b1, op: OP_DIV, a: gb, b: alu_rsp.rem};
            end else if (gb == 64'd1) begin
              stride <= cand;
              state  <= S_DONE;
            end else begin
              cand    <= cand_inc;
              gb      <= total_chunks;
              alu_req <= '{go: 1'b1, op: OP_DIV, a: cand_inc, b: total_chunks};
            end
          end
        end
        S_K1: begin
          if (alu_rsp.done) begin
            res_x   <= alu_rsp.rem[30:0];
            alu_req <= '{go: 1'b1, op: OP_DIV, a: alu_rsp.quo, b: {33'd0, grid_y}};
            state   <= S_K2;
          end
        end
        // Key complete: step the walk by the stride modulo the total.
        S_K2: begin
          if (alu_rsp.done) begin
            res_y     <= alu_rsp.rem[30:0];
            res_z     <= alu_rsp.quo[30:0];
            res_level <= pyramid_level;
            remaining <= remaining_dec;
            res_last  <= (remaining_dec == '0);
            position  <= (stride >= gap) ? (stride - gap) : (position + stride);
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {3'd0, res_x, res_y, res_z, res_level, res_sel};
            m_tuser  <= res_status;
            m_tlast  <= res_last;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_alu_free, alu_req.go |-> !alu_rsp.busy, "shared unit started while busy")
  `ASSERT_CLK(a_key_left, (state == S_K2 && alu_rsp.done) |-> (remaining != '0),
              "key finished with nothing remaining")
  `ASSERT_CLK(a_pos_range, (state == S_IDLE && remaining != '0) |-> (position < total_chunks),
              "walk position outside the grid")

endmodule

`default_nettype wire

FILE: design/cgss_alu.sv
// ----------------------------------------------------------------------------
// cgss_alu
// Shared radix-2 unit: 64-bit restoring divide or shift-add multiply,
// one bit per cycle over one 65-bit adder.
// ----------------------------------------------------------------------------
`default_nettype none

module cgss_alu (
  input  wire              clk,
  input  wire              rst,
  input  cgss_pkg::alu_req_t req,
  output cgss_pkg::alu_rsp_t rsp
);
  import cgss_pkg::*;

  logic [CNT_W-1:0] cnt;
  alu_op_t          op;
  logic [63:0]      xr;
  logic [63:0]      yr;
  logic [64:0]      acc;
  logic             done;
  logic [64:0]      opa;
  logic [64:0]      opb;
  logic [65:0]      sum;
  logic             ge;

  // One adder serves both operations; for division it subtracts.
  always_comb begin
    opa = (op == OP_DIV) ? {acc[63:0], xr[63]} : acc;
    opb = {1'b0, yr};
    sum = {1'b0, opa} + {1'b0, ((op == OP_DIV) ? ~opb : opb)} + {65'd0, (op == OP_DIV)};
    ge  = sum[65];
  end

  // Step sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go && cnt == '0) begin
        cnt <= CNT_W'(WORD_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (req.go && cnt == '0) begin
      op  <= req.op;
      xr  <= req.a;
      yr  <= req.b;
      acc <= '0;
    end else if (cnt != '0) begin
      if (op == OP_DIV) begin
        xr  <= {xr[62:0], ge};
        acc <= ge ? sum[64:0] : opa;
      end else begin
        xr <= {1'b0, xr[63:1]};
        yr <= {yr[62:0], 1'b0};
        if (xr[0]) begin
          acc <= {1'b0, sum[63:0]};
        end
      end
    end
  end

  assign rsp.busy = (cnt != '0);
  assign rsp.done = done;
  assign rsp.quo  = xr;
  assign rsp.rem  = acc[63:0];

endmodule

`default_nettype wire

FILE: bench/cgss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgss_checker
// Watches the configuration, request and result channels of the chunk grid
// stride sampler, predicts every result from its own copy of the state and
// compares each result transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module cgss_checker (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  input  wire          s_tready,
  input  wire  [31:0]  s_tdata,
  input  wire  [0:0]   s_tuser,
  input  wire          m_tvalid,
  input  wire          m_tready,
  input  wire  [143:0] m_tdata,
  input  wire  [1:0]   m_tuser,
  input  wire          m_tlast,
  input  wire          cfg_valid,
  input  wire          cfg_ready,
  input  wire  [2:0]   cfg_index,
  input  wire  [63:0]  cfg_data,
  output int           fail_count,
  output int           pending
);
  import cgss_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] sel;
    logic [15:0] level;
    logic [30:0] kz;
    logic [30:0] ky;
    logic [30:0] kx;
    logic        last;
  } chunk_key_t;

  chunk_key_t expected_keys[$];

  // Configuration copy.
  logic [30:0] vol_z, vol_y, vol_x, blk_z, blk_y, blk_x;
  logic [15:0] lvl;
  logic [63:0] seed;

  // Walk state.
  logic [63:0] grid_z, grid_y, grid_x, total, step, pos;
  logic [31:0] left;

  function automatic logic [63:0] splitmix(input logic [63:0] v);
    logic [63:0] t;
    t = v + MIX_ADD;
    t = (t ^ (t >> 30)) * MIX_M1;
    t = (t ^ (t >> 27)) * MIX_M2;
    return t ^ (t >> 31);
  endfunction

  function automatic logic [63:0] gcd(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  // Works out the result of one request and advances the walk state.
  function automatic chunk_key_t predict_chunk_key(input logic req, input logic [31:0] wanted);
    chunk_key_t  r;
    logic [127:0] prod;
    logic [63:0] gz, gy, gx, t, s, p, yz, gap;
    r = '{ST_OK, 32'd0, 16'd0, 31'd0, 31'd0, 31'd0, 1'b0};
    if (req == REQ_START) begin
      if (vol_z == 0 || vol_y == 0 || vol_x == 0 || blk_z == 0 || blk_y == 0 || blk_x == 0) begin
        left = '0;
        r.status = ST_BAD_SHAPE;
        return r;
      end
      gz = (64'(vol_z) + 64'(blk_z) - 64'd1) / 64'(blk_z);
      gy = (64'(vol_y) + 64'(blk_y) - 64'd1) / 64'(blk_y);
      gx = (64'(vol_x) + 64'(blk_x) - 64'd1) / 64'(blk_x);
      grid_z = gz;
      grid_y = gy;
      grid_x = gx;
      prod = 128'(gz) * 128'(gy) * 128'(gx);
      if (prod[127:64] != 0) begin
        left = '0;
        r.status = ST_OVERFLOW;
        return r;
      end
      t = prod[63:0];
      total = t;
      left = (64'(wanted) < t) ? wanted : t[31:0];
      r.sel = left;
      if (left == 0) return r;
      pos = splitmix(seed) % t;
      s = (t == 64'd1) ? 64'd1 : splitmix(seed + 64'd1) % t;
      if (s == 0) s = 64'd1;
      while (gcd(s, t) != 1) begin
        s++;
        if (s == t) s = 64'd1;
      end
      step = s;
      return r;
    end
    if (left == 0 || total == 0 || grid_x == 0 || grid_y == 0) begin
      r.status = ST_EXHAUSTED;
      return r;
    end
    p = pos;
    yz = p / grid_x;
    r.level = lvl;
    r.kx = 31'(p % grid_x);
    r.ky = 31'(yz % grid_y);
    r.kz = 31'(yz / grid_y);
    left--;
    r.last = (left == 0);
    // Exact modular advance, no 64-bit wrap.
    gap = total - p;
    pos = (step >= gap) ? step - gap : p + step;
    return r;
  endfunction

  assign pending = expected_keys.size();

  always @(posedge clk) begin
    chunk_key_t exp_key, got;
    if (rst) begin
      vol_z <= 31'd1; vol_y <= 31'd1; vol_x <= 31'd1;
      blk_z <= 31'd1; blk_y <= 31'd1; blk_x <= 31'd1;
      lvl <= '0; seed <= '0;
      grid_z <= 64'd1; grid_y <= 64'd1; grid_x <= 64'd1;
      total <= 64'd1; step <= 64'd1; pos <= '0; left <= '0;
      expected_keys.delete();
    end else begin
      // Register writes.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SHAPE_Z: vol_z = cfg_data[30:0];
          REG_SHAPE_Y: vol_y = cfg_data[30:0];
          REG_SHAPE_X: vol_x = cfg_data[30:0];
          REG_CHUNK_Z: blk_z = cfg_data[30:0];
          REG_CHUNK_Y: blk_y = cfg_data[30:0];
          REG_CHUNK_X: blk_x = cfg_data[30:0];
          REG_LEVEL:   lvl   = cfg_data[15:0];
          REG_SEED:    seed  = cfg_data;
          default: ;
        endcase
      end
      // Result transaction against the oldest prediction.
      if (m_tvalid && m_tready) begin
        got = '{m_tuser, m_tdata[31:0], m_tdata[47:32], m_tdata[78:48],
                m_tdata[109:79], m_tdata[140:110], m_tlast};
        if (expected_keys.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: status=%0d sel=%0d", got.status, got.sel);
        end else begin
          exp_key = expected_keys.pop_front();
          if (got != exp_key || m_tdata[143:141] != 0) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp st=%0d sel=%0d lvl=%0d z=%0d y=%0d x=%0d last=%0d | got st=%0d sel=%0d lvl=%0d z=%0d y=%0d x=%0d last=%0d",
                       exp_key.status, exp_key.sel, exp_key.level, exp_key.kz, exp_key.ky,
                       exp_key.kx, exp_key.last, got.status, got.sel, got.level, got.kz,
                       got.ky, got.kx, got.last);
          end
        end
      end
      // Request transaction: its prediction joins the tail of the queue.
      if (s_tvalid && s_tready)
        expected_keys.insert(expected_keys.size(), predict_chunk_key(s_tuser[0], s_tdata));
    end
  end

  initial fail_count = 0;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives configurations and start/next request sequences into the chunk grid
// stride sampler with random idling on both streams, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import cgss_pkg::*;

  logic          clk;
  logic          rst;
  logic          s_tvalid;
  logic          s_tready;
  logic [31:0]   s_tdata;   // wanted_count[31:0]
  logic [0:0]    s_tuser;   // req_type[0]
  logic          m_tvalid;
  logic          m_tready;
  logic [143:0]  m_tdata;   // selected_count, key_level, key_z, key_y, key_x, zero
  logic [1:0]    m_tuser;   // status[1:0]
  logic          m_tlast;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [2:0]    cfg_index;
  logic [63:0]   cfg_data;
  int            fail_count;
  int            pending;
  int            sent;
  logic          calm;
  logic          hold_arm;
  logic          hold;
  int            rx_wait;

  chunk_grid_stride_sampler i_dut (.*);

  cgss_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous overall limit.
  initial begin
    #100ms;
    $display("[chunk_grid_stride_sampler] ERROR");
    $finish;
  end

  // Long receiver hold-off, counted here, while requests keep coming.
  initial begin
    hold = 1'b0;
    wait (hold_arm);
    @(posedge clk);
    hold <= 1'b1;
    repeat (1500) @(posedge clk);
    hold <= 1'b0;
  end

  // Result side: random wait per result transaction.
  initial begin
    m_tready = 1'b0;
    rx_wait = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready)
        rx_wait = calm ? 0 : $urandom_range(0, 6);
      if (hold || rst) begin
        m_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        m_tready <= 1'b0;
        rx_wait--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_request(input logic req, input logic [31:0] wanted);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= wanted;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  // One register write, with cfg_valid dropped after it to keep writes apart.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_shape(input logic [30:0] vz, vy, vx, bz, by, bx);
    write_reg(REG_SHAPE_Z, 64'(vz));
    write_reg(REG_SHAPE_Y, 64'(vy));
    write_reg(REG_SHAPE_X, 64'(vx));
    write_reg(REG_CHUNK_Z, 64'(bz));
    write_reg(REG_CHUNK_Y, 64'(by));
    write_reg(REG_CHUNK_X, 64'(bx));
  endtask

  initial begin
    int n;
    int k;
    logic [30:0] big;
    big = 31'h7fffffff;
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    calm = 1'b0; hold_arm = 1'b0; sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: exhausted after reset, default single-chunk grid.
    send_request(REQ_NEXT, 32'hffffffff);
    send_request(REQ_START, 32'd0);
    send_request(REQ_NEXT, 32'd0);
    send_request(REQ_START, 32'd5);
    send_request(REQ_NEXT, 32'd0);
    send_request(REQ_NEXT, 32'd0);
    settle();

    // Zero extent on a chunk register, then exhausted after the failed start.
    write_reg(REG_CHUNK_Y, 64'd0);
    send_request(REQ_START, 32'd3);
    send_request(REQ_NEXT, 32'd0);
    settle();

    // Grid product beyond 64 bits.
    write_shape(big, big, big, 31'd1, 31'd1, 31'd1);
    send_request(REQ_START, 32'd7);
    send_request(REQ_NEXT, 32'd0);
    settle();

    // A large total that still fits, all-ones seed and level.
    write_shape(big, big, 31'd3, 31'd1, 31'd1, 31'd1);
    write_reg(REG_LEVEL, 64'hffff);
    write_reg(REG_SEED, 64'hffffffffffffffff);
    send_request(REQ_START, 32'hffffffff);
    repeat (4) send_request(REQ_NEXT, 32'd0);
    settle();

    // Chunks larger than the volume, full-width chunk registers.
    write_shape(31'd5, 31'd9, 31'd2, big, big, big);
    write_reg(REG_LEVEL, 64'd0);
    write_reg(REG_SEED, 64'd0);
    send_request(REQ_START, 32'd2);
    repeat (2) send_request(REQ_NEXT, 32'd0);
    settle();

    // Random phases: start then a walk of next requests, with some noise.
    k = 0;
    while (sent < 1150) begin
      settle();
      repeat (200) @(posedge clk);
      k++;
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 19))
        0: write_shape(31'($urandom_range(0, 3)), 31'($urandom_range(0, 3)),
                       31'($urandom_range(0, 3)), 31'($urandom_range(0, 3)),
                       31'($urandom_range(0, 3)), 31'($urandom_range(0, 3)));
        1: write_shape(31'($urandom) | 31'h40000000, 31'($urandom) | 31'h40000000,
                       31'($urandom_range(1, 4)), 31'($urandom_range(1, 2)),
                       31'($urandom_range(1, 2)), 31'd1);
        2: write_shape(31'($urandom), 31'($urandom), 31'($urandom),
                       31'($urandom_range(1, 3)), 31'($urandom_range(1, 3)),
                       31'($urandom_range(1, 3)));
        default: write_shape(31'($urandom_range(1, 300)), 31'($urandom_range(1, 300)),
                             31'($urandom_range(1, 300)), 31'($urandom_range(1, 40)),
                             31'($urandom_range(1, 40)), 31'($urandom_range(1, 40)));
      endcase
      write_reg(REG_LEVEL, 64'($urandom));
      write_reg(REG_SEED, {$urandom, $urandom});
      n = $urandom_range(0, 40);
      if ($urandom_range(0, 9) == 0) send_request(REQ_START, $urandom);
      else send_request(REQ_START, n);
      if (k == 3) hold_arm = 1'b1;
      n = n + $urandom_range(0, 2);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 29) == 0) send_request(REQ_START, $urandom);
        else send_request(REQ_NEXT, $urandom);
      end
    end

    settle();
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[chunk_grid_stride_sampler] OK");
    end else begin
      $display("[chunk_grid_stride_sampler] ERROR");
    end
    $finish;
  end

endmodule

FILE: chunk_grid_stride_sampler.f
+incdir+design
design/cgss_pkg.sv
design/cgss_alu.sv
design/chunk_grid_stride_sampler.sv
bench/cgss_checker.sv
bench/tb_top.sv
